// File: rtl/ssh_pkg.sv
package ssh_pkg;

    // Width of the length field that the block actually uses
    localparam int LENGTH_WIDTH = 32;

    localparam logic [31:0] MIX_SEED    = 32'hd3cccc57;
    localparam logic [31:0] CRC32C_POLY = 32'h82F63B78;

    // Rotate amounts of the mix hash
    localparam int ROT_A = 14;
    localparam int ROT_B = 11;
    localparam int ROT_C = 25;
    localparam int ROT_D = 16;

    // Bits folded per CRC call
    localparam int CRC_WORD_BITS = 32;
    localparam int CRC_BYTE_BITS = 8;

    // Register map: address width, and the value of byte address bit 2 for the mode register
    localparam int  CFG_ADDR_W   = 3;
    localparam logic CFG_IDX_MODE = 1'b0;

    typedef logic [3:0][7:0] t_word;

    // Rotate left by a constant amount in 1..31
    function automatic logic [31:0] f_rotl(input logic [31:0] x, input int r);
        return (x << r) | (x >> (32 - r));
    endfunction

    // Reflected CRC-32C over the low nbits of data, no inversion
    function automatic logic [31:0] f_crc(input logic [31:0] crc, input logic [31:0] data,
                                          input int nbits);
        logic [31:0] c;
        c = crc ^ data;
        for (int i = 0; i < 32; i++) begin
            if (i < nbits) begin
                c = (c >> 1) ^ (c[0] ? CRC32C_POLY : 32'h0);
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/sparse_string_hash.sv
// Sparse string hash. Strings arrive one byte per request, offset zero first,
// with the total length repeated on every request; the block takes one byte
// per clock unless it holds o_stall. Only sampled bytes are kept: for length 4
// or more, four little-endian words at offsets 0, len-4, len/2-2 and len/4-1;
// for length 1 to 3, the bytes at 0, len-1 and len/2. One 32-bit hash leaves
// after the last byte, through a capture register, a first hash stage and the
// output register. A zero-length request yields hash 0 on the same path.
// Register 0 (bit 0) selects the CRC-32C chain seeded with the length (1) or
// the xor/subtract/rotate mix (0); write it only while no string is in flight.
module sparse_string_hash (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // byte channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [7:0]                    i_data_byte,
    input  logic [31:0]                   i_string_length,
    // hash channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [31:0]                   o_hash_value,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ssh_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int LW = ssh_pkg::LENGTH_WIDTH;

    // Configuration
    logic r_use_crc;

    // Capture state
    logic [LW-1:0]        r_byte_position;
    ssh_pkg::t_word [3:0] r_words;

    // Capture register (last byte seen)
    logic                 r_fin_valid;
    ssh_pkg::t_word [3:0] r_fin_words;
    logic [31:0]          r_fin_len;
    logic                 r_fin_crc;
    logic                 r_fin_zero;

    // First hash stage
    logic        r_mid_valid;
    logic [31:0] r_mid_h;
    logic [31:0] r_mid_a;
    logic [31:0] r_mid_b;
    logic [31:0] r_mid_w2;
    logic [31:0] r_mid_w3;
    logic        r_mid_big;
    logic        r_mid_crc;
    logic        r_mid_zero;

    // Output register
    logic        r_out_valid;
    logic [31:0] r_out_hash;

    logic                 out_adv, mid_free, fin_free, in_acc;
    logic [LW-1:0]        len;
    logic                 len_zero, len_big, is_last, emit;
    logic [LW-1:0]        off [4];
    logic [LW-1:0]        rel [4];
    ssh_pkg::t_word [3:0] n_words;
    logic [31:0]          n_mid_h, n_mid_a, n_mid_b;
    logic [31:0]          n_out_hash;
    logic                 fin_big;

    // Pipeline flow
    assign out_adv  = !r_out_valid || !i_stall;
    assign mid_free = !r_mid_valid || out_adv;
    assign fin_free = !r_fin_valid || mid_free;
    assign in_acc   = i_valid && fin_free;
    assign o_stall  = !fin_free;
    assign o_valid  = r_out_valid;
    assign o_hash_value = r_out_hash;

    // Configuration port
    assign pready = 1'b1;
    assign prdata = {31'b0, r_use_crc};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_crc <= 1'b0;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == ssh_pkg::CFG_IDX_MODE) begin
            r_use_crc <= pwdata[0];
        end
    end

    // Decode length and sample positions
    assign len      = i_string_length[LW-1:0];
    assign len_zero = (len == '0);
    assign len_big  = (len >= LW'(4));
    assign is_last  = ({1'b0, r_byte_position} + (LW+1)'(1)) >= {1'b0, len};
    assign emit     = len_zero || is_last;

    assign off[0] = '0;
    assign off[1] = len - LW'(4);
    assign off[2] = (len >> 1) - LW'(2);
    assign off[3] = (len >> 2) - LW'(1);

    // Insert the byte into each sample word it falls in
    always_comb begin
        n_words = (r_byte_position == '0) ? '0 : r_words;
        for (int k = 0; k < 4; k++) begin
            rel[k] = r_byte_position - off[k];
        end
        if (len_big) begin
            for (int k = 0; k < 4; k++) begin
                if (rel[k] < LW'(4)) begin
                    n_words[k][rel[k][1:0]] = i_data_byte;
                end
            end
        end else begin
            if (r_byte_position == '0) begin
                n_words[0][0] = i_data_byte;
            end
            if (r_byte_position == len - LW'(1)) begin
                n_words[1][0] = i_data_byte;
            end
            if (r_byte_position == (len >> 1)) begin
                n_words[2][0] = i_data_byte;
            end
        end
    end

    // Advance position and samples
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_position <= '0;
            r_words         <= '0;
        end else if (in_acc) begin
            if (len_zero || is_last) begin
                r_byte_position <= '0;
            end else begin
                r_byte_position <= r_byte_position + LW'(1);
            end
            if (!len_zero) begin
                r_words <= n_words;
            end
        end
    end

    // Capture register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else if (fin_free) begin
            r_fin_valid <= in_acc && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_free && in_acc && emit) begin
            r_fin_words <= n_words;
            r_fin_len   <= 32'(len);
            r_fin_crc   <= r_use_crc;
            r_fin_zero  <= len_zero;
        end
    end

    // First hash stage: first two CRC folds, or first half of the mix
    assign fin_big = (r_fin_len >= 32'd4);

    always_comb begin
        logic [31:0] h0, h1, a0;
        h0 = r_fin_len ^ ssh_pkg::MIX_SEED ^ r_fin_words[1] ^ r_fin_words[2];
        h1 = h0 - ssh_pkg::f_rotl(r_fin_words[2], ssh_pkg::ROT_A);
        a0 = r_fin_words[0] ^ h1;
        n_mid_a = a0 - ssh_pkg::f_rotl(h1, ssh_pkg::ROT_B);
        n_mid_b = r_fin_words[2] + (fin_big ? 32'(r_fin_words[3]) : 32'h0);
        if (r_fin_crc) begin
            if (fin_big) begin
                n_mid_h = ssh_pkg::f_crc(
                    ssh_pkg::f_crc(r_fin_len, r_fin_words[0], ssh_pkg::CRC_WORD_BITS),
                    r_fin_words[1], ssh_pkg::CRC_WORD_BITS);
            end else begin
                n_mid_h = ssh_pkg::f_crc(
                    ssh_pkg::f_crc(r_fin_len, {24'h0, r_fin_words[0][0]},
                                   ssh_pkg::CRC_BYTE_BITS),
                    {24'h0, r_fin_words[1][0]}, ssh_pkg::CRC_BYTE_BITS);
            end
        end else begin
            n_mid_h = h1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_valid <= 1'b0;
        end else if (mid_free) begin
            r_mid_valid <= r_fin_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mid_free && r_fin_valid) begin
            r_mid_h    <= n_mid_h;
            r_mid_a    <= n_mid_a;
            r_mid_b    <= n_mid_b;
            r_mid_w2   <= r_fin_words[2];
            r_mid_w3   <= r_fin_words[3];
            r_mid_big  <= fin_big;
            r_mid_crc  <= r_fin_crc;
            r_mid_zero <= r_fin_zero;
        end
    end

    // Second hash stage: last CRC folds, or second half of the mix
    always_comb begin
        logic [31:0] b0, b1, h2;
        b0 = r_mid_b ^ r_mid_a;
        b1 = b0 - ssh_pkg::f_rotl(r_mid_a, ssh_pkg::ROT_C);
        h2 = r_mid_h ^ b1;
        if (r_mid_zero) begin
            n_out_hash = '0;
        end else if (r_mid_crc) begin
            if (r_mid_big) begin
                n_out_hash = ssh_pkg::f_crc(
                    ssh_pkg::f_crc(r_mid_h, r_mid_w2, ssh_pkg::CRC_WORD_BITS),
                    r_mid_w3, ssh_pkg::CRC_WORD_BITS);
            end else begin
                n_out_hash = ssh_pkg::f_crc(r_mid_h, {24'h0, r_mid_w2[7:0]},
                                            ssh_pkg::CRC_BYTE_BITS);
            end
        end else begin
            n_out_hash = h2 - ssh_pkg::f_rotl(b1, ssh_pkg::ROT_D);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_mid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_mid_valid) begin
            r_out_hash <= n_out_hash;
        end
    end

`ifndef SYNTHESIS
    a_zero_len_rewinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && len_zero |=> r_byte_position == '0)
        else $error("byte position not rewound after empty string");

    a_mid_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !emit |=> r_byte_position == $past(r_byte_position) + LW'(1))
        else $error("byte position did not advance");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_fin_valid && r_mid_valid && r_out_valid)
        else $error("input stalled with room in the pipeline");

    a_empty_gives_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mid_valid && r_mid_zero && out_adv |=> o_valid && o_hash_value == '0)
        else $error("empty string did not hash to zero");

    a_last_captured: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && emit |=> r_fin_valid)
        else $error("last byte not captured");
`endif

endmodule

// File: dv/sparse_string_hash_tb.sv
module sparse_string_hash_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] HASH_SEED    = 32'hd3cccc57;
    localparam logic [31:0] CRC_POLY_REV = 32'h82F63B78;
    localparam logic [31:0] LEN_MASK     = 32'((64'd1 << ssh_pkg::LENGTH_WIDTH) - 1);
    localparam logic [ssh_pkg::CFG_ADDR_W-1:0] ADDR_USE_CRC = '0;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int SETTLE_TICKS = 10;
    localparam int PHASE_REQS   = 230;

    typedef struct {
        logic [7:0]  data;
        logic [31:0] len;
        bit          drain_first;
    } t_byte_req;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_valid;
    logic                           o_stall;
    logic [7:0]                     i_data_byte;
    logic [31:0]                    i_string_length;
    logic                           o_valid;
    logic                           i_stall;
    logic [31:0]                    o_hash_value;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [ssh_pkg::CFG_ADDR_W-1:0] paddr;
    logic [31:0]                    pwdata;
    logic [31:0]                    prdata;
    logic                           pready;

    // Byte requests waiting to be driven and hashes waiting to come out
    t_byte_req   pending_bytes[$];
    logic [31:0] hash_expect[$];
    int          reqs_queued;
    int          reqs_taken;
    int          fail_count;
    int          cycle_count;
    int          send_idle_pct;
    int          stall_pct;
    bit          byte_taken;

    // Hash predictor state
    bit          crc_mode;
    logic [31:0] str_pos;
    logic [31:0] samples [4];

    sparse_string_hash dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_data_byte     (i_data_byte),
        .i_string_length (i_string_length),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_hash_value    (o_hash_value),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    function automatic logic [31:0] rot_left(input logic [31:0] x, input int r);
        logic [63:0] dbl;
        dbl = {x, x} << r;
        return dbl[63:32];
    endfunction

    function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [31:0] data,
                                             input int nbits);
        logic [31:0] c;
        c = crc ^ data;
        repeat (nbits) c = c[0] ? ((c >> 1) ^ CRC_POLY_REV) : (c >> 1);
        return c;
    endfunction

    // Fold the captured samples into the final hash
    function automatic logic [31:0] string_digest(input logic [31:0] len);
        logic [31:0] a, b, h;
        if (crc_mode) begin
            h = len;
            if (len >= 4) begin
                for (int k = 0; k < 4; k++) h = crc_fold(h, samples[k], 32);
            end else begin
                for (int k = 0; k < 3; k++) h = crc_fold(h, {24'h0, samples[k][7:0]}, 8);
            end
            return h;
        end
        h = len ^ HASH_SEED;
        a = samples[0];
        h ^= samples[1];
        b = samples[2];
        h ^= b;
        h -= rot_left(b, 14);
        if (len >= 4) b += samples[3];
        a ^= h;
        a -= rot_left(h, 11);
        b ^= a;
        b -= rot_left(a, 25);
        h ^= b;
        h -= rot_left(b, 16);
        return h;
    endfunction

    // Store a byte into sample word k when it falls inside that word's window
    function automatic void place_byte(input int k, input logic [31:0] rel, input logic [7:0] d);
        if (rel < 4) samples[k][rel[1:0]*8 +: 8] = d;
    endfunction

    // Advance the predictor by one byte; return 1 when a hash is due
    function automatic bit absorb_byte(input logic [7:0] d, input logic [31:0] raw_len,
                                       output logic [31:0] h);
        logic [31:0] pos, len;
        pos = str_pos;
        len = raw_len & LEN_MASK;
        h = '0;
        if (len == 0) begin
            str_pos = '0;
            return 1'b1;
        end
        if (pos == 0) begin
            foreach (samples[k]) samples[k] = '0;
        end
        if (len >= 4) begin
            place_byte(0, pos, d);
            place_byte(1, pos - (len - 32'd4), d);
            place_byte(2, pos - ((len >> 1) - 32'd2), d);
            place_byte(3, pos - ((len >> 2) - 32'd1), d);
        end else begin
            if (pos == 0) place_byte(0, 0, d);
            if (pos == len - 32'd1) place_byte(1, 0, d);
            if (pos == (len >> 1)) place_byte(2, 0, d);
        end
        if ({1'b0, pos} + 33'd1 >= {1'b0, len}) begin
            str_pos = '0;
            h = string_digest(len);
            return 1'b1;
        end
        str_pos = pos + 32'd1;
        return 1'b0;
    endfunction

    task automatic push_req(input logic [7:0] d, input logic [31:0] len, input bit drain = 1'b0);
        t_byte_req r;
        r.data = d;
        r.len = len;
        r.drain_first = drain;
        pending_bytes.push_back(r);
        reqs_queued++;
    endtask

    task automatic push_string(input logic [31:0] len, input bit drain);
        for (int i = 0; i < len; i++) push_req(8'($urandom_range(255)), len, drain && i == 0);
    endtask

    // Mostly whole strings, with empty requests and strings cut or re-sized midway
    task automatic queue_random(input int count);
        int target, kind, k;
        logic [31:0] len;
        target = reqs_queued + count;
        while (reqs_queued < target) begin
            kind = $urandom_range(99);
            if (kind < 10) begin
                push_req(8'($urandom_range(255)), 32'd0);
            end else if (kind < 85) begin
                k = $urandom_range(99);
                len = (k < 75) ? $urandom_range(1, 12) :
                      (k < 97) ? $urandom_range(13, 64) : $urandom_range(65, 260);
                push_string(len, $urandom_range(19) == 0);
            end else begin
                len = $urandom();
                if (len < 8) len = len + 32'd8;
                k = $urandom_range(1, 6);
                for (int i = 0; i < k; i++) push_req(8'($urandom_range(255)), len);
                case ($urandom_range(2))
                    0: begin
                        push_req(8'($urandom_range(255)), 32'd0);
                    end
                    1: begin
                        push_req(8'($urandom_range(255)), $urandom_range(1, k + 1));
                    end
                    default: begin
                        len = k + 2 + $urandom_range(20);
                        for (int i = k; i < len; i++) push_req(8'($urandom_range(255)), len);
                    end
                endcase
            end
        end
    endtask

    // Write the mode register, then read it back
    task automatic write_mode(input bit mode);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_USE_CRC;
        pwdata <= {31'b0, mode};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        crc_mode = mode;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== {31'b0, mode}) begin
            $error("use_crc_path: expected %0h, actual %0h", {31'b0, mode}, prdata);
            fail_count++;
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Hold until every request is taken and every hash has arrived
    task automatic wait_idle();
        while (pending_bytes.size() != 0 || reqs_taken != reqs_queued || hash_expect.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Abort on a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL sparse_string_hash");
            $finish;
        end
    end

    // Drive byte requests and receiver stall at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || byte_taken) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct &&
                !(pending_bytes[0].drain_first && hash_expect.size() != 0)) begin
                i_valid <= 1'b1;
                i_data_byte <= pending_bytes[0].data;
                i_string_length <= pending_bytes[0].len;
                void'(pending_bytes.pop_front());
            end else begin
                i_valid <= 1'b0;
            end
        end
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // Check hashes and predict from accepted bytes at the rising edge
    always @(posedge i_clk) begin
        logic [31:0] want;
        if (!i_rst_n) begin
            byte_taken <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (hash_expect.size() == 0) begin
                    $error("hash_value: expected none, actual %08h", o_hash_value);
                    fail_count++;
                end else begin
                    want = hash_expect.pop_front();
                    if (o_hash_value !== want) begin
                        $error("hash_value: expected %08h, actual %08h", want, o_hash_value);
                        fail_count++;
                    end
                end
            end
            if (i_valid && !o_stall) begin
                if (absorb_byte(i_data_byte, i_string_length, want)) hash_expect.push_back(want);
                reqs_taken++;
            end
            byte_taken <= i_valid && !o_stall;
        end
    end

    initial begin
        int phase_mode[5]  = '{1, 0, 1, 0, 1};
        int phase_idle[5]  = '{0, 82, 0, 16, 16};
        int phase_stall[5] = '{0, 0, 82, 16, 16};
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data_byte = '0;
        i_string_length = '0;
        i_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        send_idle_pct = 0;
        stall_pct = 0;
        crc_mode = 1'b0;
        str_pos = '0;
        foreach (samples[k]) samples[k] = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_mode(1'b0);
        // empty string ignores its byte
        push_req(8'hFF, 32'd0);
        // one- to three-byte strings, mostly at byte extremes
        push_req(8'h00, 32'd1);
        push_req(8'hFF, 32'd1);
        push_req(8'hFF, 32'd2);
        push_req(8'h00, 32'd2);
        push_req(8'hA5, 32'd3);
        push_req(8'h5A, 32'd3);
        push_req(8'hFF, 32'd3);
        push_string(32'd4, 1'b0);
        // huge length cut short by a smaller one
        push_req(8'h3C, 32'hFFFF_FFFF);
        push_req(8'hC3, 32'd2);
        // empty request in the middle of a string drops it
        push_req(8'h11, 32'd5);
        push_req(8'h22, 32'd0);
        push_string(32'd8, 1'b1);
        wait_idle();

        for (int p = 0; p < 5; p++) begin
            send_idle_pct = phase_idle[p];
            stall_pct = phase_stall[p];
            write_mode(phase_mode[p][0]);
            queue_random(PHASE_REQS);
            wait_idle();
        end

        if (fail_count == 0) begin
            $display("PASS sparse_string_hash");
        end else begin
            $display("FAIL sparse_string_hash");
        end
        $finish;
    end

endmodule
